/* rtl/core/block_cache_lru_tags_defines.svh */
// Assertion macros for the block_cache_lru_tags checker.
`ifndef BLOCK_CACHE_LRU_TAGS_DEFINES_SVH
`define BLOCK_CACHE_LRU_TAGS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BCLT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("block_cache_lru_tags: check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BCLT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("block_cache_lru_tags: check failed");

`endif

/* rtl/core/bclt_pkg.sv */
// Shared types and constants of the block cache tag and age tracker.
`timescale 1ns / 1ps

package bclt_pkg;

  localparam int ENTRIES    = 20;
  localparam int AGE_BITS   = 32;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WORD_W     = 32;
  localparam int WAY_W      = 5;
  localparam int OUTCOME_W  = 2;
  localparam int OUT_DATA_W = 40;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [AGE_BITS-1:0] age_t;
  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [WAY_W-1:0]    way_t;

  localparam idx_t LAST_IDX = idx_t'(ENTRIES - 1);

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_PASS = 2'd0,
    OUT_HIT  = 2'd1,
    OUT_MISS = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load_pass;  // present an uncompressed word as a passthrough result
    logic start;      // latch magnitude, bump age counter, rewind the scan
    logic step;       // examine one entry
    logic commit;     // write back the hit or the fill and present the result
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic match;  // entry under the scan pointer holds the requested tag
    logic last;   // scan pointer sits on the final entry
  } sts_t;

  // Fit an entry index into the result's way field.
  function automatic way_t to_way(idx_t i);
    way_t w;
    w = '0;
    for (int b = 0; b < WAY_W && b < IDX_W; b++) begin
      w[b] = i[b];
    end
    return w;
  endfunction

endpackage

/* rtl/core/bclt_ctrl.sv */
// Controller state machine of the block cache tag and age tracker.
`timescale 1ns / 1ps

module bclt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_sign,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  bclt_pkg::sts_t sts,
  output bclt_pkg::cmd_t cmd
);

  bclt_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;
  logic accept;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    in_tready     = (state_r == bclt_pkg::ST_IDLE) && out_free;
    accept        = in_tvalid && in_tready;
    cmd.load_pass = accept && !in_sign;
    cmd.start     = accept && in_sign;
    cmd.step      = (state_r == bclt_pkg::ST_SCAN);
    cmd.commit    = (state_r == bclt_pkg::ST_UPDATE) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bclt_pkg::ST_IDLE: begin
        if (cmd.start) state_nxt = bclt_pkg::ST_SCAN;
      end
      bclt_pkg::ST_SCAN: begin
        if (sts.match || sts.last) state_nxt = bclt_pkg::ST_UPDATE;
      end
      bclt_pkg::ST_UPDATE: begin
        if (cmd.commit) state_nxt = bclt_pkg::ST_IDLE;
      end
      default: state_nxt = bclt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.load_pass || cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bclt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/core/bclt_dpath.sv */
// Datapath of the block cache tag and age tracker: tags, ages, scan and result.
`timescale 1ns / 1ps

module bclt_dpath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bclt_pkg::word_t       in_word,
  input  bclt_pkg::cmd_t        cmd,
  output bclt_pkg::sts_t        sts,
  output bclt_pkg::outcome_t    out_outcome,
  output bclt_pkg::way_t        out_way,
  output bclt_pkg::word_t       out_block_number
);

  bclt_pkg::word_t tag_r [bclt_pkg::ENTRIES];
  bclt_pkg::age_t  age_r [bclt_pkg::ENTRIES];
  bclt_pkg::age_t  counter_r, counter_nxt;

  bclt_pkg::word_t mag_r;
  bclt_pkg::idx_t  idx_r;
  bclt_pkg::idx_t  hit_idx_r;
  bclt_pkg::idx_t  vic_r;
  bclt_pkg::age_t  best_r;
  logic            hit_r;

  bclt_pkg::outcome_t out_outcome_r;
  bclt_pkg::way_t     out_way_r;
  bclt_pkg::word_t    out_bn_r;

  bclt_pkg::idx_t  wb_idx;
  logic            take_vic;

  assign counter_nxt = counter_r + bclt_pkg::age_t'(1);
  assign sts.match   = (tag_r[idx_r] == mag_r);
  assign sts.last    = (idx_r == bclt_pkg::LAST_IDX);
  assign take_vic    = (idx_r == '0) || (age_r[idx_r] < best_r);
  assign wb_idx      = hit_r ? hit_idx_r : vic_r;

  assign out_outcome      = out_outcome_r;
  assign out_way          = out_way_r;
  assign out_block_number = out_bn_r;

  // Cache state: tags, ages and the global counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r <= '0;
      for (int i = 0; i < bclt_pkg::ENTRIES; i++) begin
        tag_r[i] <= '0;
        age_r[i] <= '0;
      end
    end else if (cmd.start) begin
      counter_r <= counter_nxt;
      if (counter_nxt == '0) begin
        for (int i = 0; i < bclt_pkg::ENTRIES; i++) begin
          age_r[i] <= '0;
        end
      end
    end else if (cmd.commit) begin
      age_r[wb_idx] <= counter_r;
      if (!hit_r) tag_r[wb_idx] <= mag_r;
    end
  end

  // Scan pointer, hit record and running minimum.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mag_r <= bclt_pkg::word_t'(0) - in_word;
      idx_r <= '0;
      hit_r <= 1'b0;
    end else if (cmd.step) begin
      if (!sts.last) idx_r <= idx_r + bclt_pkg::idx_t'(1);
      if (sts.match) begin
        hit_r     <= 1'b1;
        hit_idx_r <= idx_r;
      end
      if (take_vic) begin
        vic_r  <= idx_r;
        best_r <= age_r[idx_r];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_pass) begin
      out_outcome_r <= bclt_pkg::OUT_PASS;
      out_way_r     <= '0;
      out_bn_r      <= in_word;
    end else if (cmd.commit) begin
      out_outcome_r <= hit_r ? bclt_pkg::OUT_HIT : bclt_pkg::OUT_MISS;
      out_way_r     <= bclt_pkg::to_way(wb_idx);
      out_bn_r      <= mag_r;
    end
  end

endmodule

/* rtl/core/block_cache_lru_tags.sv */
// Top level of the block cache tag and age tracker.
// Tag and age bookkeeping for a small fully associative block cache with
// least-recently-used replacement. Each request carries one signed 32-bit
// block-offset word. A non-negative word is an uncompressed block and comes
// back as a passthrough result (outcome 0, way 0) in the next cycle with no
// state change. A negative word names a compressed block by its magnitude
// (the most negative word counts as 2^31): the global age counter advances
// (ages are all cleared when it wraps to zero), then the entries are scanned
// one tag and age pair per cycle. A hit refreshes that entry's age; a miss
// fills the first entry of smallest age with the new tag and counter value.
// The scan walks the entry registers in order and stops at the hit entry,
// or covers all ENTRIES entries on a miss. Tags reset to zero and never
// match, so no valid bits are kept. One request is in work at a time; a
// result held in the output register blocks the next request until it is
// taken, which may happen in the same cycle.
`timescale 1ns / 1ps

module block_cache_lru_tags (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input request channel.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bclt_pkg::WORD_W-1:0]     in_tdata,    // [31:0] offset_word (signed)
  // Result channel.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bclt_pkg::OUT_DATA_W-1:0] out_tdata    // [1:0] outcome, [6:2] way,
                                                       // [38:7] block_number, [39] zero
);

  bclt_pkg::cmd_t     cmd;
  bclt_pkg::sts_t     sts;
  bclt_pkg::outcome_t outcome;
  bclt_pkg::way_t     way;
  bclt_pkg::word_t    block_number;

  // Sequence accept, scan and write-back; own the output valid flag.
  bclt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_sign    (in_tdata[bclt_pkg::WORD_W-1]),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Hold tags, ages, counter, scan registers and the result payload.
  bclt_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_word          (in_tdata),
    .cmd              (cmd),
    .sts              (sts),
    .out_outcome      (outcome),
    .out_way          (way),
    .out_block_number (block_number)
  );

  // Pack result fields from the lowest bit up; pad to whole bytes.
  assign out_tdata = {1'b0, block_number, way, outcome};

endmodule

/* rtl/core/bclt_checker.sv */
// Port-level checker for block_cache_lru_tags, with its bind.
`timescale 1ns / 1ps
`include "block_cache_lru_tags_defines.svh"

module bclt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [bclt_pkg::WORD_W-1:0]     in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bclt_pkg::OUT_DATA_W-1:0] out_tdata
);

  // A stalled result holds.
  `BCLT_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // An uncompressed request comes back next cycle, unchanged, as a passthrough.
  `BCLT_ASSERT_NXT(a_pass_next, in_tvalid && in_tready && !in_tdata[31], out_tvalid && (out_tdata[1:0] == bclt_pkg::OUT_PASS) && (out_tdata[38:7] == $past(in_tdata)) && (out_tdata[6:2] == '0))

  // A compressed request occupies the block while the scan runs.
  `BCLT_ASSERT_NXT(a_busy_scan, in_tvalid && in_tready && in_tdata[31], !in_tready)

  // Cache results carry a nonzero block number and a legal outcome.
  `BCLT_ASSERT_IMP(a_cache_result, out_tvalid && (out_tdata[1:0] != bclt_pkg::OUT_PASS), ((out_tdata[1:0] == bclt_pkg::OUT_HIT) || (out_tdata[1:0] == bclt_pkg::OUT_MISS)) && (out_tdata[38:7] != '0))

endmodule

bind block_cache_lru_tags bclt_checker u_bclt_checker (.*);

/* tb/block_cache_lru_tags_tb.sv */
// Self-checking testbench of the block cache tag and age tracker.
`timescale 1ns / 1ps

module block_cache_lru_tags_tb;

  // Give up after this many cycles with no request and no result moving.
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_REQUESTS = 450;
  // Drain margin, scaled with the number of entries.
  localparam int DRAIN_CYCLES = 2 * (bclt_pkg::ENTRIES + 2) + 6;
  // Keep most compressed magnitudes in a pool a little larger than the
  // cache, so that hits, refills and evictions all happen often.
  localparam int TAG_POOL = bclt_pkg::ENTRIES + 6;

  // One expected result: the lookup outcome, the entry and the block number.
  typedef struct {
    bclt_pkg::outcome_t outcome;
    bclt_pkg::way_t     way;
    bclt_pkg::word_t    block_number;
  } lookup_t;

  // Scoreboard: keeps its own copy of the tags, the ages and the age
  // counter, predicts each lookup and holds the lookups still owed.
  class lru_tag_tracker;
    bclt_pkg::word_t tags[bclt_pkg::ENTRIES];
    bclt_pkg::age_t  ages[bclt_pkg::ENTRIES];
    bclt_pkg::age_t  stamp;
    lookup_t         owed_lookups[$];
    int              errors;

    function new();
      foreach (tags[i]) begin
        tags[i] = '0;
        ages[i] = '0;
      end
      stamp  = '0;
      errors = 0;
    endfunction

    function int pending();
      return owed_lookups.size();
    endfunction

    // Predict the lookup caused by an accepted request and queue it.
    function void note_request(bclt_pkg::word_t word);
      lookup_t         res;
      bclt_pkg::word_t mag;
      int              victim;
      bit              found;
      res.outcome      = bclt_pkg::OUT_PASS;
      res.way          = '0;
      res.block_number = word;
      if (word[bclt_pkg::WORD_W-1]) begin
        // Negate modulo 2^32: the most negative word becomes 2^31.
        mag = bclt_pkg::word_t'(0) - word;
        res.block_number = mag;
        // Advance the counter; clear every age when it wraps to zero.
        stamp = stamp + 1'b1;
        if (stamp == '0) begin
          foreach (ages[i]) ages[i] = '0;
        end
        found = 1'b0;
        for (int i = 0; i < bclt_pkg::ENTRIES; i++) begin
          if (!found && tags[i] == mag) begin
            found       = 1'b1;
            ages[i]     = stamp;
            res.outcome = bclt_pkg::OUT_HIT;
            res.way     = bclt_pkg::way_t'(i);
          end
        end
        if (!found) begin
          // Oldest entry wins; a strict compare keeps the lowest index on ties.
          victim = 0;
          for (int i = 1; i < bclt_pkg::ENTRIES; i++) begin
            if (ages[i] < ages[victim]) victim = i;
          end
          tags[victim] = mag;
          ages[victim] = stamp;
          res.outcome  = bclt_pkg::OUT_MISS;
          res.way      = bclt_pkg::way_t'(victim);
        end
      end
      owed_lookups.push_back(res);
    endfunction

    function void compare_field(string name, longint unsigned exp_val,
                                longint unsigned act_val);
      if (exp_val != act_val) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, name, exp_val, act_val);
      end
    endfunction

    // Check one accepted result against the oldest owed lookup.
    function void check_result(logic [bclt_pkg::OUT_DATA_W-1:0] data);
      lookup_t exp_res;
      if (owed_lookups.size() == 0) begin
        errors++;
        $display("%0t: result with no request owed, expected none, actual 0x%0h",
                 $time, data);
        return;
      end
      exp_res = owed_lookups.pop_front();
      compare_field("outcome", exp_res.outcome, data[1:0]);
      compare_field("way", exp_res.way, data[6:2]);
      compare_field("block_number", exp_res.block_number, data[38:7]);
      compare_field("pad bit", 0, data[39]);
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [bclt_pkg::WORD_W-1:0]     in_tdata = '0;  // [31:0] offset_word (signed)
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [bclt_pkg::OUT_DATA_W-1:0] out_tdata;      // [1:0] outcome, [6:2] way,
                                                   // [38:7] block_number, [39] zero

  lru_tag_tracker tracker = new();

  // Shared flags between the sender and the receiver processes.
  bit hold_req = 1'b0;  // ask the receiver for one long hold-off
  bit quiet = 1'b0;     // suppress random idling on both sides
  int idle_cycles = 0;

  block_cache_lru_tags DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sample both handshakes at the edge. Check the result first; it always
  // belongs to an earlier request than one accepted at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) tracker.check_result(out_tdata);
      if (in_tvalid && in_tready) tracker.note_request(in_tdata);
    end
  end

  // Watchdog: count cycles in which neither channel moves.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: stall about one cycle in five, none while quiet. On request,
  // hold off for a long stretch so the block backs up and stalls its input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (150) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= quiet || ($urandom_range(99) >= 20);
      end
    end
  end

  // Offer one request; idle first at random, then hold it until accepted.
  // Leave tvalid high afterwards so back-to-back requests need no toggle.
  task automatic offer_word(input bclt_pkg::word_t word);
    while (!quiet && $urandom_range(99) < 20) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop tvalid and wait until every owed lookup has come back.
  task automatic drain_lookups();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  initial begin
    bclt_pkg::word_t word;
    int              sel;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: passthrough extremes, the most negative word, first-entry
    // fill on the all-zero-age tie, hits on both, then fill every entry and
    // evict the least recently used one.
    offer_word(32'h0000_0000);
    offer_word(32'h7FFF_FFFF);
    offer_word(32'h8000_0000);
    offer_word(32'hFFFF_FFFF);
    offer_word(32'hFFFF_FFFF);
    offer_word(32'h8000_0000);
    for (int k = 2; k <= bclt_pkg::ENTRIES; k++) begin
      offer_word(bclt_pkg::word_t'(0) - bclt_pkg::word_t'(k));
    end

    // Random: mostly compressed words from a small tag pool, with full-range
    // compressed and uncompressed words mixed in.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == 100) hold_req = 1'b1;
      if (n == 200) drain_lookups();
      if (n == 250) quiet = 1'b1;
      if (n == 350) quiet = 1'b0;
      sel = $urandom_range(99);
      if (sel < 65) begin
        word = bclt_pkg::word_t'(0) - bclt_pkg::word_t'($urandom_range(TAG_POOL, 1));
      end else if (sel < 75) begin
        word = {1'b1, 31'($urandom)};
      end else if (sel < 78) begin
        word = 32'h8000_0000;
      end else begin
        word = {1'b0, 31'($urandom)};
      end
      offer_word(word);
    end

    drain_lookups();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/bclt_pkg.sv
rtl/core/bclt_ctrl.sv
rtl/core/bclt_dpath.sv
rtl/core/block_cache_lru_tags.sv
rtl/core/bclt_checker.sv
tb/block_cache_lru_tags_tb.sv
